[rtl/dng_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dng_pkg: shared types and constants of the note dispenser
// Note values, reciprocal constants for the greedy divide step, item types
// and the status codes.
// ----------------------------------------------------------------------------
package dng_pkg;

  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned AMOUNT_BITS = 20;

  localparam int unsigned NUM_VALUES  = 7;
  localparam int unsigned IDX_BITS    = $clog2(NUM_VALUES);
  localparam int unsigned FIELD_BITS  = 16;
  localparam int unsigned AMT_FIELD_BITS = 20;
  localparam int unsigned VALUE_BITS  = 7;

  localparam int unsigned WIDE_BITS  = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;
  localparam int unsigned RECIP_BITS = AMOUNT_BITS + 1;
  localparam int unsigned PROD_BITS  = 2 * AMOUNT_BITS + 1;
  localparam int unsigned SV_BITS    = COUNT_BITS + VALUE_BITS;
  localparam int unsigned QV_BITS    = AMOUNT_BITS + VALUE_BITS;
  localparam int unsigned CMP_BITS   = (AMOUNT_BITS > COUNT_BITS) ? AMOUNT_BITS : COUNT_BITS;
  localparam int unsigned DIFF_BITS  = (AMOUNT_BITS > SV_BITS) ? AMOUNT_BITS : SV_BITS;

  typedef logic [IDX_BITS-1:0]        idx_t;
  typedef logic [COUNT_BITS-1:0]      cnt_t;
  typedef logic [AMOUNT_BITS-1:0]     amt_t;
  typedef logic [FIELD_BITS-1:0]      field_t;
  typedef logic [VALUE_BITS-1:0]      value_t;
  typedef logic [RECIP_BITS-1:0]      recip_t;
  typedef logic [PROD_BITS-1:0]       prod_t;
  typedef logic [SV_BITS-1:0]         sv_t;
  typedef logic [QV_BITS-1:0]         qv_t;
  typedef logic [CMP_BITS-1:0]        cmp_t;
  typedef logic [DIFF_BITS-1:0]       diff_t;
  typedef logic [WIDE_BITS-1:0]       wide_t;
  typedef logic [WIDE_BITS:0]         sum_t;

  typedef logic [NUM_VALUES-1:0][COUNT_BITS-1:0] cnt_vec_t;
  typedef logic [NUM_VALUES-1:0][FIELD_BITS-1:0] field_vec_t;

  localparam idx_t LAST_IDX = idx_t'(NUM_VALUES - 1);

  localparam longint unsigned AMT_POW = 64'd1 << AMOUNT_BITS;

  // Ordered from the largest note down to the smallest.
  localparam value_t NOTE_VALUE [NUM_VALUES] = '{
    value_t'(100), value_t'(50), value_t'(20), value_t'(10),
    value_t'(5), value_t'(2), value_t'(1)
  };

  // floor(2^AMOUNT_BITS / value): the quotient estimate is at most one short.
  localparam recip_t NOTE_RECIP [NUM_VALUES] = '{
    recip_t'(AMT_POW / 100), recip_t'(AMT_POW / 50), recip_t'(AMT_POW / 20),
    recip_t'(AMT_POW / 10), recip_t'(AMT_POW / 5), recip_t'(AMT_POW / 2),
    recip_t'(AMT_POW / 1)
  };

  typedef enum logic [2:0] {
    ST_PAID      = 3'd0,
    ST_SHORT     = 3'd1,
    ST_INVALID   = 3'd2,
    ST_DEPOSITED = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef struct packed {
    logic                      mode;
    logic [AMT_FIELD_BITS-1:0] amount;
    field_t                    add_100;
    field_t                    add_50;
    field_t                    add_20;
    field_t                    add_10;
    field_t                    add_5;
    field_t                    add_2;
    field_t                    add_1;
  } in_item_t;

  typedef struct packed {
    status_e status;
    field_t  paid_100;
    field_t  paid_50;
    field_t  paid_20;
    field_t  paid_10;
    field_t  paid_5;
    field_t  paid_2;
    field_t  paid_1;
  } out_item_t;

  typedef struct packed {
    logic add_en;
    logic sub_en;
  } stock_cmd_t;

  typedef struct packed {
    cnt_t take;
    amt_t rest;
  } step_t;

  // Low field bits of a count, zero-extended when counters are narrower.
  function automatic field_t cnt_to_field(cnt_t c);
    wide_t w;
    w = wide_t'(c);
    return w[FIELD_BITS-1:0];
  endfunction

endpackage

[rtl/dng_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dng_in_if: request channel of the note dispenser
// Valid/ready handshake carrying one withdrawal or deposit item.
// ----------------------------------------------------------------------------
interface dng_in_if;
  logic               valid;
  logic               ready;
  dng_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/dng_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dng_out_if: response channel of the note dispenser
// Valid/ready handshake carrying the status and note counts of one item.
// ----------------------------------------------------------------------------
interface dng_out_if;
  logic               valid;
  logic               ready;
  dng_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/dng_stock.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dng_stock: note stock counters
// Seven counters with deposit overflow check, deposit add and payout subtract.
// ----------------------------------------------------------------------------
module dng_stock (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dng_pkg::stock_cmd_t  cmd_i,
  input  dng_pkg::field_vec_t  add_i,
  input  dng_pkg::cnt_vec_t    used_i,
  output dng_pkg::cnt_vec_t    stock_o,
  output logic                 over_o
);

  dng_pkg::cnt_vec_t stock_q, stock_d;
  logic [dng_pkg::NUM_VALUES-1:0][dng_pkg::WIDE_BITS:0] sum;

  always_comb begin
    over_o  = 1'b0;
    stock_d = stock_q;
    for (int i = 0; i < dng_pkg::NUM_VALUES; i++) begin
      sum[i] = dng_pkg::sum_t'(stock_q[i]) + dng_pkg::sum_t'(add_i[i]);
      if (|sum[i][dng_pkg::WIDE_BITS:dng_pkg::COUNT_BITS]) begin
        over_o = 1'b1;
      end
      if (cmd_i.add_en) begin
        stock_d[i] = dng_pkg::cnt_t'(sum[i]);
      end else if (cmd_i.sub_en) begin
        stock_d[i] = stock_q[i] - used_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stock_q <= '0;
    end else begin
      stock_q <= stock_d;
    end
  end

  assign stock_o = stock_q;

endmodule

[rtl/dng_greedy_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dng_greedy_unit: shared greedy step for one note value
// The first stage estimates remainder / value by a reciprocal multiply and
// forms stock * value into registers; the second stage corrects the quotient,
// bounds it by the stock and produces the notes taken and the new remainder.
// ----------------------------------------------------------------------------
module dng_greedy_unit (
  input  logic                clk_i,
  input  logic                load_i,
  input  dng_pkg::idx_t       idx_i,
  input  dng_pkg::amt_t       rest_i,
  input  dng_pkg::cnt_vec_t   stock_i,
  output dng_pkg::step_t      step_o
);

  localparam int unsigned A = dng_pkg::AMOUNT_BITS;

  dng_pkg::value_t value;
  dng_pkg::recip_t recip;
  dng_pkg::cnt_t   stock;
  dng_pkg::prod_t  prod;
  dng_pkg::amt_t   q0_d, q0_q;
  dng_pkg::sv_t    sv_d, sv_q;
  dng_pkg::qv_t    qv;
  dng_pkg::amt_t   r0;
  logic            corr;
  dng_pkg::amt_t   fit;

  assign value = dng_pkg::NOTE_VALUE[idx_i];
  assign recip = dng_pkg::NOTE_RECIP[idx_i];
  assign stock = stock_i[idx_i];

  assign prod = dng_pkg::prod_t'(rest_i) * dng_pkg::prod_t'(recip);
  assign q0_d = prod[2*A-1:A];
  assign sv_d = dng_pkg::sv_t'(stock) * dng_pkg::sv_t'(value);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      q0_q <= q0_d;
      sv_q <= sv_d;
    end
  end

  // The estimate is never high and at most one low.
  assign qv   = dng_pkg::qv_t'(q0_q) * dng_pkg::qv_t'(value);
  assign r0   = dng_pkg::amt_t'(dng_pkg::qv_t'(rest_i) - qv);
  assign corr = (r0 >= dng_pkg::amt_t'(value));
  assign fit  = q0_q + dng_pkg::amt_t'(corr);

  always_comb begin
    if (dng_pkg::cmp_t'(fit) > dng_pkg::cmp_t'(stock)) begin
      step_o.take = stock;
      step_o.rest = dng_pkg::amt_t'(dng_pkg::diff_t'(rest_i) - dng_pkg::diff_t'(sv_q));
    end else begin
      step_o.take = dng_pkg::cnt_t'(fit);
      step_o.rest = r0 - (corr ? dng_pkg::amt_t'(value) : '0);
    end
  end

endmodule

[rtl/note_dispenser_greedy.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_dispenser_greedy: cash dispenser with bounded note stock
// Greedy withdrawal over seven note values, largest first, and whole-or-none
// deposits into the stock counters.
// ----------------------------------------------------------------------------
//  channel | modport | handshake      | item
//  in_i    | sink    | valid / ready  | mode, amount, add_100 .. add_1
//  out_o   | source  | valid / ready  | status, paid_100 .. paid_1
//
// A withdrawal runs the shared greedy unit through a load step and a fit
// step for each of the seven note values, largest first.
// A deposit or a zero amount goes straight to the result step.
// The result sits in an output register; a new item is accepted while it
// waits, and the block holds a finished item until that register frees up.
// Reset clears the stock to zero; the first fill is an ordinary deposit.
// ----------------------------------------------------------------------------
module note_dispenser_greedy (
  input  logic        clk_i,
  input  logic        rst_ni,
  dng_in_if.sink      in_i,
  dng_out_if.source   out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RECIP,
    S_FIT,
    S_DONE
  } state_e;

  state_e                state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  dng_pkg::out_item_t    out_item_q, out_item_d;
  dng_pkg::idx_t         idx_q, idx_d;
  dng_pkg::amt_t         rest_q, rest_d;
  logic                  dep_q, dep_d;
  logic                  invalid_q, invalid_d;
  dng_pkg::field_vec_t   add_q, add_d;
  dng_pkg::cnt_vec_t     used_q, used_d;

  dng_pkg::stock_cmd_t   stock_cmd;
  dng_pkg::cnt_vec_t     stock;
  logic                  over;
  logic                  unit_load;
  dng_pkg::step_t        step;
  dng_pkg::amt_t         in_amount;
  logic                  out_free;
  dng_pkg::out_item_t    result;

  dng_stock u_stock (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (stock_cmd),
    .add_i   (add_q),
    .used_i  (used_q),
    .stock_o (stock),
    .over_o  (over)
  );

  dng_greedy_unit u_unit (
    .clk_i   (clk_i),
    .load_i  (unit_load),
    .idx_i   (idx_q),
    .rest_i  (rest_q),
    .stock_i (stock),
    .step_o  (step)
  );

  assign in_amount = dng_pkg::amt_t'(in_i.payload.amount);
  assign out_free  = !out_valid_q || out_o.ready;

  always_comb begin
    result = '0;
    if (dep_q) begin
      result.status = over ? dng_pkg::ST_OVERFLOW : dng_pkg::ST_DEPOSITED;
    end else if (invalid_q) begin
      result.status = dng_pkg::ST_INVALID;
    end else if (rest_q == '0) begin
      result.status   = dng_pkg::ST_PAID;
      result.paid_100 = dng_pkg::cnt_to_field(used_q[0]);
      result.paid_50  = dng_pkg::cnt_to_field(used_q[1]);
      result.paid_20  = dng_pkg::cnt_to_field(used_q[2]);
      result.paid_10  = dng_pkg::cnt_to_field(used_q[3]);
      result.paid_5   = dng_pkg::cnt_to_field(used_q[4]);
      result.paid_2   = dng_pkg::cnt_to_field(used_q[5]);
      result.paid_1   = dng_pkg::cnt_to_field(used_q[6]);
    end else begin
      result.status = dng_pkg::ST_SHORT;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_item_d  = out_item_q;
    idx_d       = idx_q;
    rest_d      = rest_q;
    dep_d       = dep_q;
    invalid_d   = invalid_q;
    add_d       = add_q;
    used_d      = used_q;
    unit_load   = 1'b0;
    stock_cmd   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          dep_d     = in_i.payload.mode;
          rest_d    = in_amount;
          invalid_d = (in_amount == '0);
          idx_d     = '0;
          add_d[0]  = in_i.payload.add_100;
          add_d[1]  = in_i.payload.add_50;
          add_d[2]  = in_i.payload.add_20;
          add_d[3]  = in_i.payload.add_10;
          add_d[4]  = in_i.payload.add_5;
          add_d[5]  = in_i.payload.add_2;
          add_d[6]  = in_i.payload.add_1;
          if (in_i.payload.mode || (in_amount == '0)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_RECIP;
          end
        end
      end
      S_RECIP: begin
        unit_load = 1'b1;
        state_d   = S_FIT;
      end
      S_FIT: begin
        rest_d        = step.rest;
        used_d[idx_q] = step.take;
        if (idx_q == dng_pkg::LAST_IDX) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_RECIP;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_item_d       = result;
          stock_cmd.add_en = dep_q && !over;
          stock_cmd.sub_en = !dep_q && !invalid_q && (rest_q == '0);
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    rest_q     <= rest_d;
    dep_q      <= dep_d;
    invalid_q  <= invalid_d;
    add_q      <= add_d;
    used_q     <= used_d;
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

endmodule

[rtl/dng_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dng_checker: port-level checks of the note dispenser
// Tracks items in flight and checks the handshakes and the payout fields.
// ----------------------------------------------------------------------------
module dng_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input dng_pkg::out_item_t out_item_i
);

  logic       in_fire;
  logic       out_fire;
  logic [1:0] pend_q;
  logic       paid_zero;

  assign in_fire   = in_valid_i && in_ready_i;
  assign out_fire  = out_valid_i && out_ready_i;
  assign paid_zero = (out_item_i.paid_100 == '0) && (out_item_i.paid_50 == '0) &&
                     (out_item_i.paid_20 == '0) && (out_item_i.paid_10 == '0) &&
                     (out_item_i.paid_5 == '0) && (out_item_i.paid_2 == '0) &&
                     (out_item_i.paid_1 == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_fire) - 2'(out_fire);
    end
  end

  // A result is never delivered without an item waiting for it.
  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (pend_q != 2'd0))
    else $error("result delivered with no item in flight");

  // At most one item in work and one result waiting.
  a_in_flight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !out_fire) |-> (pend_q <= 2'd1))
    else $error("too many items in flight");

  // Items are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_i)
    else $error("item accepted while the previous one is in work");

  // Note counts appear only on a paid result.
  a_paid_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_item_i.status != dng_pkg::ST_PAID)) |-> paid_zero)
    else $error("note counts on a result that is not paid");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_item_i)))
    else $error("result dropped or changed while stalled");

endmodule

bind note_dispenser_greedy dng_checker u_dng_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.payload)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the greedy note dispenser
// Drives withdrawal and deposit requests over the request channel, predicts
// each response from a local copy of the note stock, and compares every
// response field by field. Directed tests cover empty stock, zero amounts,
// greedy misses, full counters and deposit overflow; a long random run
// follows, with random idle cycles on both sides and a long receiver stall.
// ----------------------------------------------------------------------------
module tb_top;
  import dng_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned RANDOM_CHUNKS = 24;
  localparam int unsigned CHUNK_ITEMS   = 50;
  localparam int unsigned COUNT_MAX     = (1 << COUNT_BITS) - 1;

  logic clk_i = 1'b0;
  logic rst_ni;

  dng_in_if  in_ch ();
  dng_out_if out_ch ();

  note_dispenser_greedy uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Local copy of the stock, index 0 holds the notes of value 1.
  cnt_vec_t    note_stock_model;
  out_item_t   pending_results [$];
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned rx_hold_cycles;

  string paid_name [NUM_VALUES] = '{
    "paid_1", "paid_2", "paid_5", "paid_10", "paid_20", "paid_50", "paid_100"
  };

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles", cycle_count);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic field_vec_t paid_counts(out_item_t r);
    return {r.paid_100, r.paid_50, r.paid_20, r.paid_10, r.paid_5, r.paid_2, r.paid_1};
  endfunction

  // Applies one accepted request to the stock copy and returns its response.
  function automatic out_item_t settle_request(in_item_t it);
    field_vec_t  adds;
    field_vec_t  used;
    int unsigned rest;
    int unsigned fit;
    int unsigned take;
    int          k;
    logic        over;
    status_e     st;
    adds = {it.add_100, it.add_50, it.add_20, it.add_10, it.add_5, it.add_2, it.add_1};
    used = '0;
    if (!it.mode) begin
      rest = it.amount;
      if (rest == 0) begin
        st = ST_INVALID;
      end else begin
        for (int i = 0; i < NUM_VALUES; i++) begin
          k    = NUM_VALUES - 1 - i;
          fit  = rest / NOTE_VALUE[i];
          take = (fit < note_stock_model[k]) ? fit : note_stock_model[k];
          used[k] = field_t'(take);
          rest -= take * NOTE_VALUE[i];
        end
        if (rest == 0) begin
          st = ST_PAID;
          for (k = 0; k < NUM_VALUES; k++) note_stock_model[k] -= used[k];
        end else begin
          st   = ST_SHORT;
          used = '0;
        end
      end
    end else begin
      over = 1'b0;
      for (k = 0; k < NUM_VALUES; k++) begin
        if (int'(note_stock_model[k]) + int'(adds[k]) > COUNT_MAX) over = 1'b1;
      end
      if (over) begin
        st = ST_OVERFLOW;
      end else begin
        st = ST_DEPOSITED;
        for (k = 0; k < NUM_VALUES; k++) note_stock_model[k] += adds[k];
      end
    end
    return {st, used};
  endfunction

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("tb_top: %s", msg);
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t  want;
    field_vec_t want_paid;
    field_vec_t got_paid;
    if (pending_results.size() == 0) begin
      log_failure($sformatf("response with nothing pending, status %0d", got.status));
      return;
    end
    want      = pending_results.pop_front();
    want_paid = paid_counts(want);
    got_paid  = paid_counts(got);
    if (got.status !== want.status) begin
      log_failure($sformatf("status mismatch: expected %0d got %0d",
                            want.status, got.status));
    end
    for (int k = NUM_VALUES - 1; k >= 0; k--) begin
      if (got_paid[k] !== want_paid[k]) begin
        log_failure($sformatf("%s mismatch: expected %0d got %0d",
                              paid_name[k], want_paid[k], got_paid[k]));
      end
    end
  endfunction

  // Response side: random ready delays, plus a long hold when one is requested.
  initial begin
    int unsigned pause;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        while (rx_hold_cycles > 0) begin
          @(posedge clk_i);
          rx_hold_cycles--;
        end
      end
      pause = rx_idle_on ? $urandom_range(0, 4) : 0;
      if (pause > 0) begin
        out_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      check_result(out_ch.payload);
    end
  end

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    pending_results.push_back(settle_request(it));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic in_item_t withdrawal(int unsigned amt);
    field_vec_t noise;
    for (int k = 0; k < NUM_VALUES; k++) noise[k] = field_t'($urandom_range(0, 65535));
    return {1'b0, AMT_FIELD_BITS'(amt), noise};
  endfunction

  function automatic in_item_t deposit(field_vec_t adds);
    return {1'b1, AMT_FIELD_BITS'($urandom_range(0, 20'hFFFFF)), adds};
  endfunction

  function automatic in_item_t random_request();
    field_vec_t  adds;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // Mostly small deposits so the stock stays below the counter limit.
      if ($urandom_range(0, 9) < 8) begin
        for (int k = 0; k < NUM_VALUES; k++) adds[k] = field_t'($urandom_range(0, 20));
      end else begin
        for (int k = 0; k < NUM_VALUES; k++) adds[k] = field_t'($urandom_range(0, 65535));
      end
      return deposit(adds);
    end
    if (pick < 65) return withdrawal($urandom_range(1, 500));
    if (pick < 85) return withdrawal($urandom_range(1, 20000));
    if (pick < 97) return withdrawal($urandom_range(0, 20'hFFFFF));
    return withdrawal(0);
  endfunction

  task automatic test_empty_and_invalid();
    send_item(withdrawal(1));
    send_item(withdrawal(0));
    send_item(withdrawal(100));
  endtask

  // 50 + 3 x 20 holds 60 only without the 50, which greedy always takes first.
  task automatic test_greedy_miss();
    send_item(deposit({16'd0, 16'd1, 16'd3, 16'd0, 16'd0, 16'd0, 16'd0}));
    send_item(withdrawal(60));
    send_item(withdrawal(110));
    send_item(withdrawal(20));
    send_item(deposit({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4, 16'd1}));
    send_item(withdrawal(6));
    send_item(withdrawal(9));
  endtask

  task automatic test_counter_limits();
    send_item(deposit('0));
    send_item(deposit({NUM_VALUES{16'hFFFF}}));
    send_item(deposit('0));
    send_item(deposit({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1}));
    send_item(deposit({16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}));
    send_item(withdrawal(20'hFFFFF));
    send_item(withdrawal(188));
    send_item(withdrawal(187));
    send_item(deposit({16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}));
    send_item(deposit({16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}));
    send_item(deposit({16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}));
  endtask

  task automatic test_output_stall();
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    rx_hold_cycles = 300;
    repeat (40) send_item(random_request());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    for (int c = 0; c < RANDOM_CHUNKS; c++) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      repeat (CHUNK_ITEMS) send_item(random_request());
      if (c % 8 == 7) wait_drained();
    end
  endtask

  initial begin
    fail_count       = 0;
    cycle_count      = 0;
    rx_hold_cycles   = 0;
    tx_idle_on       = 1'b1;
    rx_idle_on       = 1'b1;
    note_stock_model = '0;
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_invalid();
    test_greedy_miss();
    test_counter_limits();
    wait_drained();
    test_output_stall();
    test_random_traffic();

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/dng_pkg.sv
rtl/dng_in_if.sv
rtl/dng_out_if.sv
rtl/dng_stock.sv
rtl/dng_greedy_unit.sv
rtl/note_dispenser_greedy.sv
rtl/dng_checker.sv
dv/tb_top.sv
